[rtl/shc_pkg.sv]
package shc_pkg;

    // Fixed field widths of the payload beats.
    localparam int KEY_WIDTH   = 32;
    localparam int TERMS_WIDTH = 6;
    localparam int CFG_DATA_W  = 6;
    localparam int CFG_INDEX_W = 1;

    localparam int STORE_DEPTH_DEFAULT = 32;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_OR_MODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TERMS   = 1'd1;

    localparam logic [TERMS_WIDTH-1:0] TERMS_RESET = 6'd1;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] article_key;
        logic                 batch_end;
    } cand_t;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] hit_key;
        logic                 hit_valid;
        logic                 last_hit;
        logic                 overflowed;
    } hit_t;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;
        logic step;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic hit_now;
        logic pend_valid;
        logic out_free;
    } dp_stat_t;

endpackage

[rtl/sorted_hit_collator.sv]
// Collects article keys, one beat per cycle while collecting, into a chain
// of STORE_DEPTH cells that keeps them sorted as they arrive. The beat
// flagged batch_end starts collation: the chain then shifts its keys out
// lowest first, one per cycle except while a new hit waits for a stalled
// result beat. Once the chain is empty and the output register is free,
// the final result is loaded and the block returns to collecting. In
// AND mode a key is a hit when it occurs terms_required times, in OR mode each
// distinct key is a hit. Hits leave in ascending order and the last one carries
// last_hit. A batch without hits gives a single beat with hit_valid clear.
// Keys arriving after the store is full are dropped and every result of the
// batch shows overflowed. While draining, no new key is taken; the next batch
// may start as soon as the final result is in the output register.
// Configuration must be written only while idle; the block does not check this.
module sorted_hit_collator #(
    parameter int STORE_DEPTH = shc_pkg::STORE_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [shc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [shc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            cand_valid,
    output logic                            cand_stall,
    input  shc_pkg::cand_t                  cand,
    output logic                            res_valid,
    input  logic                            res_stall,
    output shc_pkg::hit_t                   res
);

    shc_pkg::dp_cmd_t  cmd;
    shc_pkg::dp_stat_t stat;
    shc_pkg::state_t   state;

    // The controller sequences collect, drain and finish phases.
    shc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cand_valid (cand_valid),
        .batch_end  (cand.batch_end),
        .cand_stall (cand_stall),
        .stat       (stat),
        .cmd        (cmd),
        .state      (state)
    );

    // The datapath holds the sorted chain, the run counter, the pending hit
    // that waits to learn whether it is the last one, and the output register.
    shc_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key       (cand.article_key),
        .cmd       (cmd),
        .stat      (stat),
        .res       (res),
        .res_valid (res_valid),
        .res_stall (res_stall)
    );

    // A no-hit beat is always the final beat of its batch and carries key zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.hit_valid) |-> (res.last_hit && (res.hit_key == '0)))
        else $error("no-hit beat is not a final zero beat");

    // A stalled result beat stays in place and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(res)))
        else $error("stalled result beat changed");

    // A batch end moves the block into the drain, which holds off new keys.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cand_valid && !cand_stall && cand.batch_end) |=>
            (cand_stall && (state == shc_pkg::ST_DRAIN)))
        else $error("batch end did not start the drain");

    // Stepping the chain only happens with keys left to drain.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (!stat.count_zero && (state == shc_pkg::ST_DRAIN)))
        else $error("drain step with an empty chain");

endmodule

[rtl/shc_ctrl.sv]
module shc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cand_valid,
    input  logic              batch_end,
    output logic              cand_stall,
    input  shc_pkg::dp_stat_t stat,
    output shc_pkg::dp_cmd_t  cmd,
    output shc_pkg::state_t   state
);

    shc_pkg::state_t state_reg;
    shc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= shc_pkg::ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cand_stall = 1'b1;
        case (state_reg)
            shc_pkg::ST_COLLECT:
            begin
                cand_stall = 1'b0;
                cmd.insert = cand_valid;
                if (cand_valid && batch_end)
                begin
                    state_next = shc_pkg::ST_DRAIN;
                end
            end
            shc_pkg::ST_DRAIN:
            begin
                if (stat.count_zero)
                begin
                    state_next = shc_pkg::ST_FINISH;
                end
                else if (!(stat.hit_now && stat.pend_valid) || stat.out_free)
                begin
                    // A new hit pushes the pending one out, which needs a free slot.
                    cmd.step = 1'b1;
                end
            end
            shc_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = shc_pkg::ST_COLLECT;
                end
            end
            default:
            begin
                state_next = shc_pkg::ST_COLLECT;
            end
        endcase
    end

    assign state = state_reg;

endmodule

[rtl/shc_dp.sv]
module shc_dp #(
    parameter int STORE_DEPTH = shc_pkg::STORE_DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [shc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [shc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [shc_pkg::KEY_WIDTH-1:0]      key,
    input  shc_pkg::dp_cmd_t                   cmd,
    output shc_pkg::dp_stat_t                  stat,
    output shc_pkg::hit_t                      res,
    output logic                               res_valid,
    input  logic                               res_stall
);

    localparam int KW = shc_pkg::KEY_WIDTH;
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int NW = (CW > shc_pkg::TERMS_WIDTH) ? CW : shc_pkg::TERMS_WIDTH;

    logic [KW-1:0]                   cell_reg  [STORE_DEPTH];
    logic [KW-1:0]                   cell_next [STORE_DEPTH];
    logic [STORE_DEPTH-1:0]          gt;
    logic [CW-1:0]                   count_reg, count_next;
    logic                            ovf_reg, ovf_next;
    logic [CW-1:0]                   run_reg, run_next;
    logic [KW-1:0]                   cur_reg, cur_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic [KW-1:0]                   pend_key_reg, pend_key_next;
    logic                            res_valid_reg, res_valid_next;
    shc_pkg::hit_t                   res_reg, res_next;
    logic                            or_mode_reg;
    logic [shc_pkg::TERMS_WIDTH-1:0] terms_reg;
    logic [shc_pkg::TERMS_WIDTH-1:0] need;
    logic                            full;
    logic                            same;
    logic [CW-1:0]                   run_step;
    logic                            out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            or_mode_reg <= 1'b0;
            terms_reg   <= shc_pkg::TERMS_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == shc_pkg::REG_OR_MODE)
            begin
                or_mode_reg <= cfg_data[0];
            end
            else if (cfg_index == shc_pkg::REG_TERMS)
            begin
                terms_reg <= cfg_data[shc_pkg::TERMS_WIDTH-1:0];
            end
        end
    end

    assign need = or_mode_reg ? shc_pkg::TERMS_WIDTH'(1) : terms_reg;
    assign full = (count_reg == CW'(STORE_DEPTH));

    // Sorted chain: each cell compares its key with the incoming one, and
    // every cell above the insertion point moves up by one.
    for (genvar i = 0; i < STORE_DEPTH; i++)
    begin : g_cell
        logic          gt_prev;
        logic [KW-1:0] upper;
        logic [KW-1:0] lower;

        assign gt[i] = (CW'(i) < count_reg) && (cell_reg[i] > key);

        if (i > 0)
        begin : g_lo
            assign gt_prev = gt[i-1];
            assign lower   = cell_reg[i-1];
        end
        else
        begin : g_lo0
            assign gt_prev = 1'b0;
            assign lower   = cell_reg[i];
        end

        if (i < STORE_DEPTH - 1)
        begin : g_up
            assign upper = cell_reg[i+1];
        end
        else
        begin : g_up_last
            assign upper = cell_reg[i];
        end

        always_comb
        begin
            cell_next[i] = cell_reg[i];
            if (cmd.step)
            begin
                cell_next[i] = upper;
            end
            else if (cmd.insert && !full)
            begin
                if (gt_prev)
                begin
                    cell_next[i] = lower;
                end
                else if (gt[i] || (CW'(i) == count_reg))
                begin
                    cell_next[i] = key;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    // Run tracking on the lowest cell while the chain drains downward.
    assign same     = (run_reg != '0) && (cell_reg[0] == cur_reg);
    assign run_step = same ? (run_reg + CW'(1)) : CW'(1);
    assign out_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        run_next        = run_reg;
        cur_next        = cur_reg;
        pend_valid_next = pend_valid_reg;
        pend_key_next   = pend_key_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg && res_stall;

        if (cmd.insert)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end

        if (cmd.step)
        begin
            count_next = count_reg - CW'(1);
            run_next   = run_step;
            cur_next   = cell_reg[0];
            if (stat.hit_now)
            begin
                if (pend_valid_reg)
                begin
                    res_next.hit_key    = pend_key_reg;
                    res_next.hit_valid  = 1'b1;
                    res_next.last_hit   = 1'b0;
                    res_next.overflowed = ovf_reg;
                    res_valid_next      = 1'b1;
                end
                pend_valid_next = 1'b1;
                pend_key_next   = cell_reg[0];
            end
        end

        if (cmd.finish)
        begin
            res_next.hit_key    = pend_valid_reg ? pend_key_reg : '0;
            res_next.hit_valid  = pend_valid_reg;
            res_next.last_hit   = 1'b1;
            res_next.overflowed = ovf_reg;
            res_valid_next      = 1'b1;
            pend_valid_next     = 1'b0;
            count_next          = '0;
            ovf_next            = 1'b0;
            run_next            = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            run_reg        <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            run_reg        <= run_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        pend_key_reg <= pend_key_next;
        res_reg      <= res_next;
    end

    assign stat.count_zero = (count_reg == '0);
    assign stat.hit_now    = (NW'(run_step) == NW'(need));
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = out_free;

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule

[tb/sorted_hit_collator_test.sv]
`timescale 1ns / 1ps

// Self-checking bench for the sorted hit collator.
// A directed table comes first: extreme keys, both modes, run lengths longer
// than the term count, term counts of zero and above the store depth, mode
// writes with junk in the upper data bits, and a batch that overruns the store
// and loses its own closing key. A random part follows, in phases of random
// configuration, each made of well-formed batches built from repeated keys,
// store overruns and noise batches of unrelated keys.
// Every accepted result beat is checked field by field against a batch
// collator that lives in this file.
module sorted_hit_collator_test;

    localparam int KEY_WIDTH     = shc_pkg::KEY_WIDTH;
    localparam int TERMS_WIDTH   = shc_pkg::TERMS_WIDTH;
    localparam int CFG_DATA_W    = shc_pkg::CFG_DATA_W;
    localparam int CFG_INDEX_W   = shc_pkg::CFG_INDEX_W;
    localparam int DEPTH         = shc_pkg::STORE_DEPTH_DEFAULT;
    // The settle wait is sized from a full drain of the store and the finish of the batch.
    localparam int SETTLE_CYCLES = DEPTH + 8;
    localparam int LONG_HOLD     = 150;
    localparam int RANDOM_ITEMS  = 240;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DIRECTED_ROWS = 20;

    typedef enum {
        ROW_KEY,
        ROW_CFG
    } row_kind_t;

    // One line of the directed table. A key row sends its key reps times and
    // sets batch_end on the last copy when ends is set. A checked row carries
    // the single result beat that its batch must give.
    typedef struct {
        row_kind_t                kind;
        logic [CFG_INDEX_W-1:0]   idx;
        logic [KEY_WIDTH-1:0]     value;
        int                       reps;
        bit                       ends;
        bit                       checked;
        shc_pkg::hit_t            want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   cand_valid;
    logic                   cand_stall;
    shc_pkg::cand_t         cand;
    logic                   res_valid;
    logic                   res_stall;
    shc_pkg::hit_t          res;

    sorted_hit_collator #(
        .STORE_DEPTH(DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cand_valid (cand_valid),
        .cand_stall (cand_stall),
        .cand       (cand),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    // Collator state kept by the bench: the keys of the open batch, its
    // overflow flag and the two configuration registers.
    bit [KEY_WIDTH-1:0]   held_keys[$];
    bit                   held_overflow;
    bit                   or_sel;
    bit [TERMS_WIDTH-1:0] terms_sel;

    // Result beats still owed by the block, oldest first.
    shc_pkg::hit_t        pending_hits[$];

    int fail_count;
    int keys_accepted;
    int batches_closed;
    int overflow_batches;
    int beats_checked;
    int empty_batches;
    int reg_writes;
    int random_items;
    int burst_left;

    stim_row_t directed_rows[DIRECTED_ROWS];

    // The clock runs with a 2 ns period; everything the bench drives changes
    // on the falling edge, and the block's outputs are sampled on the rising one.
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic shc_pkg::hit_t make_hit(input bit [KEY_WIDTH-1:0] key, input bit valid,
                                               input bit last, input bit ovf);
        shc_pkg::hit_t h;
        h.hit_key    = key;
        h.hit_valid  = valid;
        h.last_hit   = last;
        h.overflowed = ovf;
        return h;
    endfunction

    // Takes one accepted key into the open batch. On batch_end the batch is
    // sorted, runs of equal keys are counted, and one beat per qualifying key
    // is queued in ascending order, or a no-hit beat if none qualifies. A
    // checked directed row queues its typed beat in place of the computed ones.
    task automatic absorb_key(input bit [KEY_WIDTH-1:0] key, input bit last,
                              input bit typed_on, input shc_pkg::hit_t typed);
        bit [KEY_WIDTH-1:0] sorted[$];
        bit [KEY_WIDTH-1:0] v;
        bit [KEY_WIDTH-1:0] cur;
        shc_pkg::hit_t      h;
        int                 i;
        int                 j;
        int                 run;
        int                 need;
        int                 hits;
        keys_accepted++;
        if (held_keys.size() < DEPTH)
        begin
            held_keys.push_back(key);
        end
        else
        begin
            // A full store drops the key, the closing one included.
            held_overflow = 1'b1;
        end
        if (last)
        begin
            sorted = held_keys;
            for (i = 1; i < sorted.size(); i++)
            begin
                v = sorted[i];
                j = i;
                while (j > 0 && sorted[j - 1] > v)
                begin
                    sorted[j] = sorted[j - 1];
                    j--;
                end
                sorted[j] = v;
            end
            // OR mode is the same count rule with a run of one.
            need = or_sel ? 1 : int'(terms_sel);
            run  = 0;
            hits = 0;
            cur  = '0;
            if (typed_on)
            begin
                pending_hits.push_back(typed);
            end
            else
            begin
                for (i = 0; i < sorted.size(); i++)
                begin
                    if (run != 0 && sorted[i] == cur)
                    begin
                        run++;
                    end
                    else
                    begin
                        cur = sorted[i];
                        run = 1;
                    end
                    // A run longer than the count still yields one hit.
                    if (run == need)
                    begin
                        pending_hits.push_back(make_hit(cur, 1'b1, 1'b0, held_overflow));
                        hits++;
                    end
                end
                if (hits == 0)
                begin
                    pending_hits.push_back(make_hit('0, 1'b0, 1'b1, held_overflow));
                end
                else
                begin
                    h = pending_hits.pop_back();
                    h.last_hit = 1'b1;
                    pending_hits.push_back(h);
                end
            end
            batches_closed++;
            if (held_overflow)
            begin
                overflow_batches++;
            end
            held_keys.delete();
            held_overflow = 1'b0;
        end
    endtask

    // Offers one key beat and holds it until the block takes it. The sender
    // works in bursts; between bursts valid drops for a random gap while the
    // payload wanders, which the block must ignore.
    task automatic send_key(input bit [KEY_WIDTH-1:0] key, input bit last,
                            input bit typed_on, input shc_pkg::hit_t typed);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                cand_valid = 1'b0;
                cand.article_key = $urandom;
                cand.batch_end = 1'($urandom_range(0, 1));
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        cand_valid       = 1'b1;
        cand.article_key = key;
        cand.batch_end   = last;
        @(posedge clk);
        while (cand_stall)
        begin
            @(posedge clk);
        end
        absorb_key(key, last, typed_on, typed);
        @(negedge clk);
    endtask

    // Registers change only while the block is idle: every owed beat has
    // arrived and the drain has had time to settle.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cand_valid = 1'b0;
        while (pending_hits.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        // Only bit 0 of the mode register exists; the rest of the data is lost.
        if (idx == shc_pkg::REG_OR_MODE)
        begin
            or_sel = data[0];
        end
        else if (idx == shc_pkg::REG_TERMS)
        begin
            terms_sel = data[TERMS_WIDTH-1:0];
        end
        reg_writes++;
    endtask

    // Mixes full random keys with small values and values near the top so
    // that every key bit sees both levels.
    function automatic bit [KEY_WIDTH-1:0] pick_key();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return KEY_WIDTH'($urandom_range(0, 15));
            2: return {KEY_WIDTH{1'b1}} - KEY_WIDTH'($urandom_range(0, 15));
            default: return KEY_WIDTH'($urandom_range(0, 255)) << (KEY_WIDTH - 8);
        endcase
    endfunction

    // Builds one batch and sends it in shuffled order. Most batches repeat
    // each key close to the term count so that some keys just make it and
    // others just miss; the rest overrun the store or are plain noise.
    task automatic random_batch();
        bit [KEY_WIDTH-1:0] keys[$];
        bit [KEY_WIDTH-1:0] k;
        bit [KEY_WIDTH-1:0] t;
        int                 kind;
        int                 d;
        int                 copies;
        int                 tr;
        int                 lo;
        int                 n;
        int                 j;
        kind = $urandom_range(0, 9);
        tr   = int'(terms_sel);
        if (kind <= 6)
        begin
            d = (!or_sel && tr > 8) ? 1 : $urandom_range(1, 6);
            repeat (d)
            begin
                k = pick_key();
                if (or_sel || tr == 0 || tr > DEPTH)
                begin
                    copies = $urandom_range(1, 3);
                end
                else
                begin
                    lo = (tr > 1) ? tr - 1 : 1;
                    copies = $urandom_range(lo, tr + 1);
                end
                repeat (copies) keys.push_back(k);
            end
        end
        else if (kind == 7)
        begin
            n = $urandom_range(DEPTH - 2, DEPTH + 8);
            repeat (n) keys.push_back(KEY_WIDTH'($urandom_range(0, 11)));
        end
        else
        begin
            n = $urandom_range(1, 8);
            repeat (n) keys.push_back($urandom);
        end
        for (j = keys.size() - 1; j > 0; j--)
        begin
            n = $urandom_range(0, j);
            t = keys[j];
            keys[j] = keys[n];
            keys[n] = t;
        end
        for (j = 0; j < keys.size(); j++)
        begin
            send_key(keys[j], j == keys.size() - 1, 1'b0, '0);
        end
        random_items += keys.size();
    endtask

    task automatic check_field(input string what, input logic [KEY_WIDTH-1:0] want,
                               input logic [KEY_WIDTH-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h, got %h", $time, what, want, got);
            fail_count++;
        end
    endtask

    // Every accepted result beat is matched against the oldest owed beat.
    always @(posedge clk)
    begin : result_check
        shc_pkg::hit_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_hits.size() == 0)
            begin
                $display("%0t: result beat %h arrived with nothing owed", $time, res);
                fail_count++;
            end
            else
            begin
                want = pending_hits.pop_front();
                beats_checked++;
                if (!want.hit_valid)
                begin
                    empty_batches++;
                end
                check_field("hit_key", want.hit_key, res.hit_key);
                check_field("hit_valid", KEY_WIDTH'(want.hit_valid), KEY_WIDTH'(res.hit_valid));
                check_field("last_hit", KEY_WIDTH'(want.last_hit), KEY_WIDTH'(res.last_hit));
                check_field("overflowed", KEY_WIDTH'(want.overflowed),
                            KEY_WIDTH'(res.overflowed));
            end
        end
    end

    // The receiver runs through segments of its own: free flow, light and
    // heavy random stalls, and stalls on alternate cycles. Every ninth
    // segment it holds off for a long stretch while the sender keeps
    // offering keys, so the block backs up and stalls its input.
    initial
    begin : stall_pattern
        int seg;
        int len;
        int mode;
        res_stall = 1'b0;
        seg = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            seg++;
            if (seg % 9 == 4)
            begin
                res_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(8, 60);
                repeat (len)
                begin
                    case (mode)
                        0: res_stall = 1'b0;
                        1: res_stall = ($urandom_range(0, 3) == 0);
                        2: res_stall = ~res_stall;
                        default: res_stall = ($urandom_range(0, 3) != 0);
                    endcase
                    @(negedge clk);
                end
            end
        end
    end

    // A hung handshake ends the run here.
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("sorted_hit_collator: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t row;
        bit        or_bit;
        int        pick;
        int        terms_pick;

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        cand_valid    = 1'b0;
        cand          = '0;
        or_sel        = 1'b0;
        terms_sel     = shc_pkg::TERMS_RESET;
        held_overflow = 1'b0;
        fail_count    = 0;
        keys_accepted = 0;
        batches_closed = 0;
        overflow_batches = 0;
        beats_checked = 0;
        empty_batches = 0;
        reg_writes    = 0;
        random_items  = 0;
        burst_left    = 0;

        // Directed table. The first rows run with the reset configuration,
        // an AND of a single term, which lets every distinct key through.
        directed_rows = '{
            '{ROW_KEY, shc_pkg::REG_OR_MODE, 32'h0000_0000, 1, 1'b1, 1'b1,
              '{32'h0000_0000, 1'b1, 1'b1, 1'b0}},
            '{ROW_KEY, shc_pkg::REG_OR_MODE, 32'hFFFF_FFFF, 1, 1'b1, 1'b1,
              '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0}},
            '{ROW_KEY, shc_pkg::REG_OR_MODE, 32'h0000_0005, 2, 1'b0, 1'b0, '0},
            '{ROW_KEY, shc_pkg::REG_OR_MODE, 32'h0000_0003, 1, 1'b1, 1'b0, '0},
            // Two terms: a run of three must give one hit, lone keys none.
            '{ROW_CFG, shc_pkg::REG_TERMS,   32'd2,         0, 1'b0, 1'b0, '0},
            '{ROW_KEY, shc_pkg::REG_OR_MODE, 32'h0000_0007, 3, 1'b0, 1'b0, '0},
            '{ROW_KEY, shc_pkg::REG_OR_MODE, 32'h0000_0009, 1, 1'b0, 1'b0, '0},
            '{ROW_KEY, shc_pkg::REG_OR_MODE, 32'h0000_0006, 1, 1'b1, 1'b0, '0},
            '{ROW_KEY, shc_pkg::REG_OR_MODE, 32'h0000_0001, 1, 1'b1, 1'b1,
              '{32'h0000_0000, 1'b0, 1'b1, 1'b0}},
            // A term count of zero can never be met.
            '{ROW_CFG, shc_pkg::REG_TERMS,   32'd0,         0, 1'b0, 1'b0, '0},
            '{ROW_KEY, shc_pkg::REG_OR_MODE, 32'h0000_0004, 2, 1'b1, 1'b1,
              '{32'h0000_0000, 1'b0, 1'b1, 1'b0}},
            // Neither can one above the store depth.
            '{ROW_CFG, shc_pkg::REG_TERMS,   32'd63,        0, 1'b0, 1'b0, '0},
            '{ROW_KEY, shc_pkg::REG_OR_MODE, 32'h0000_0008, 1, 1'b1, 1'b1,
              '{32'h0000_0000, 1'b0, 1'b1, 1'b0}},
            // OR mode, written with the upper data bits set.
            '{ROW_CFG, shc_pkg::REG_OR_MODE, 32'h0000_003F, 0, 1'b0, 1'b0, '0},
            '{ROW_KEY, shc_pkg::REG_OR_MODE, 32'hAAAA_AAAA, 2, 1'b0, 1'b0, '0},
            '{ROW_KEY, shc_pkg::REG_OR_MODE, 32'h5555_5555, 1, 1'b1, 1'b0, '0},
            // Back to AND with junk above bit 0, then a count of the store depth.
            '{ROW_CFG, shc_pkg::REG_OR_MODE, 32'h0000_003E, 0, 1'b0, 1'b0, '0},
            '{ROW_CFG, shc_pkg::REG_TERMS,   32'd32,        0, 1'b0, 1'b0, '0},
            // Thirty-three copies: the store fills, the closing copy is
            // dropped, and the full run still counts as a hit.
            '{ROW_KEY, shc_pkg::REG_OR_MODE, 32'hFFFF_FFFF, 33, 1'b1, 1'b1,
              '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1}},
            // The overflow flag must not leak into the next batch.
            '{ROW_KEY, shc_pkg::REG_OR_MODE, 32'h0000_0002, 1, 1'b1, 1'b1,
              '{32'h0000_0000, 1'b0, 1'b1, 1'b0}}
        };

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            row = directed_rows[r];
            if (row.kind == ROW_CFG)
            begin
                write_reg(row.idx, row.value[CFG_DATA_W-1:0]);
            end
            else
            begin
                for (int k = 0; k < row.reps; k++)
                begin
                    send_key(row.value, row.ends && k == row.reps - 1, row.checked, row.want);
                end
            end
        end

        // Random phases. Each phase picks a mode and a term count, with the
        // extremes of the count drawn often, and then runs a few batches.
        while (random_items < RANDOM_ITEMS)
        begin
            or_bit = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 9);
            case (pick)
                0: terms_pick = 1;
                1: terms_pick = DEPTH;
                2: terms_pick = 0;
                3: terms_pick = $urandom_range(DEPTH + 1, 63);
                default: terms_pick = $urandom_range(2, 4);
            endcase
            write_reg(shc_pkg::REG_OR_MODE, {5'($urandom_range(0, 31)), or_bit});
            write_reg(shc_pkg::REG_TERMS, CFG_DATA_W'(terms_pick));
            repeat ($urandom_range(2, 5)) random_batch();
        end

        cand_valid = 1'b0;
        while (pending_hits.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d keys in %0d batches (%0d overrun the store), %0d register writes.",
                 keys_accepted, batches_closed, overflow_batches, reg_writes);
        $display("Checked %0d result beats, %0d of them from batches without hits.",
                 beats_checked, empty_batches);
        if (fail_count == 0)
        begin
            $display("sorted_hit_collator: match");
        end
        else
        begin
            $display("sorted_hit_collator: mismatch");
        end
        $finish;
    end

endmodule

[files.f]
rtl/shc_pkg.sv
rtl/shc_ctrl.sv
rtl/shc_dp.sv
rtl/sorted_hit_collator.sv
tb/sorted_hit_collator_test.sv
